// ----- hdl/omx_pkg.sv -----
// omx_pkg: shared types, field widths, register codes and the quarter-wave sine table
// for the omni wheel motor mixer; used by every other file of the block
`default_nettype none

package omx_pkg;

  localparam int PWM_BITS_DEF  = 10;
  localparam int TRIG_FRAC_DEF = 15;
  localparam int TBL_FRAC      = 15;

  localparam int DEG_W      = 9;
  localparam int VEL_W      = 11;
  localparam int TURN_W     = 12;
  localparam int PWM_W      = 10;
  localparam int SPEED_W    = 10;
  localparam int WHEELS     = 4;
  localparam int WHEEL_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int TRIG_MAG_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALL   = 2'd0,
    REG_MAX     = 2'd1,
    REG_REVERSE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_SUMP,
    MUL_SUMM,
    MUL_VELP,
    MUL_VELM
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_SUMP,
    ST_SUMM,
    ST_VELP,
    ST_VELM,
    ST_WHEEL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               load;
    logic               trig;
    logic               mul_en;
    mul_sel_t           mul_sel;
    logic               wheel_en;
    logic [WHEEL_W-1:0] wheel_idx;
  } omx_cmd_t;

  typedef struct packed {
    logic brake;
  } omx_stat_t;

  // sin(k deg) * 2^15, k = 0..90
  localparam logic [15:0] QSINE [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,  16'd3993,
    16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,  16'd8481,
    16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275, 16'd12803,
    16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886, 16'd16384, 16'd16877,
    16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
    16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965,
    16'd24351, 16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197,
    16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
    16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
    16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643, 16'd32688, 16'd32723,
    16'd32748, 16'd32763, 16'd32768
  };

  // table entry rescaled to frac fraction bits, round half up when narrowing
  function automatic logic [TRIG_MAG_W-1:0] trig_mag(input logic [6:0] idx, input int frac);
    logic [TRIG_MAG_W:0] q;
    q = {2'b00, QSINE[idx]};
    if (frac < TBL_FRAC) begin
      q = (q + ((TRIG_MAG_W+1)'(1) << (TBL_FRAC - frac - 1))) >> (TBL_FRAC - frac);
    end else begin
      q = q << (frac - TBL_FRAC);
    end
    return q[TRIG_MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/omx_if.sv -----
// omx_if: valid/ready channel interfaces for mixer requests and wheel results
// depends on omx_pkg for field widths
`default_nettype none

interface omx_in_if;
  logic                               valid;
  logic                               ready;
  logic                               brake;
  logic signed [omx_pkg::DEG_W-1:0]   direction_deg;
  logic signed [omx_pkg::VEL_W-1:0]   speed_cmd;
  logic signed [omx_pkg::TURN_W-1:0]  turn_cmd;

  modport source (output valid, brake, direction_deg, speed_cmd, turn_cmd, input ready);
  modport sink   (input valid, brake, direction_deg, speed_cmd, turn_cmd, output ready);
endinterface

interface omx_out_if;
  logic                       valid;
  logic                       ready;
  logic [omx_pkg::PWM_W-1:0]  fl_pwm;
  logic [omx_pkg::PWM_W-1:0]  fr_pwm;
  logic [omx_pkg::PWM_W-1:0]  bl_pwm;
  logic [omx_pkg::PWM_W-1:0]  br_pwm;
  logic                       fl_dir;
  logic                       fr_dir;
  logic                       bl_dir;
  logic                       br_dir;

  modport source (output valid, fl_pwm, fr_pwm, bl_pwm, br_pwm,
                  fl_dir, fr_dir, bl_dir, br_dir, input ready);
  modport sink   (input valid, fl_pwm, fr_pwm, bl_pwm, br_pwm,
                  fl_dir, fr_dir, bl_dir, br_dir, output ready);
endinterface

`default_nettype wire

// ----- hdl/omni_wheel_motor_mixer.sv -----
// omni_wheel_motor_mixer: four-wheel omni drive mixer, top level
// depends on omx_pkg, omx_if, omx_ctrl and omx_datapath
//
// Usage:
//   in_chan carries one request: brake, direction_deg, speed_cmd, turn_cmd.
//   out_chan returns one result per request: four PWM magnitudes and four
//   direction pin levels (front left, front right, back left, back right).
//   cfg_we/cfg_index/cfg_wdata write stall_speed (0), max_speed (1) and
//   reverse_mask (2); other indexes are ignored. Write only while idle.
//   A drive request steps through TRIG, SUMP, SUMM, VELP, VELM and the wheel
//   stage before its result shows on out_chan; a brake request goes from TRIG
//   straight to the result. One request is in flight at a time: in_chan.ready
//   is high only while idle. The cost of a drive request is set by the single
//   shared multiplier (four passes) and the wheel stage, which finishes one
//   wheel per cycle.
//   If the receiver stalls, the result holds on out_chan and no new request
//   is taken until it is accepted.
//   Reset (rst_n low, synchronous) empties the block, sets stall_speed 0,
//   max_speed 1023, reverse_mask 0 and the held directions to zero.
`default_nettype none

module omni_wheel_motor_mixer #(
  parameter int PWM_BITS       = omx_pkg::PWM_BITS_DEF,
  parameter int TRIG_FRAC_BITS = omx_pkg::TRIG_FRAC_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  omx_in_if.sink                            in_chan,
  omx_out_if.source                         out_chan,
  input  wire                               cfg_we,
  input  wire [omx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [omx_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  omx_pkg::omx_cmd_t             cmd;
  omx_pkg::omx_stat_t            stat;
  logic [omx_pkg::PWM_W-1:0]     pwm [omx_pkg::WHEELS];
  logic [omx_pkg::WHEELS-1:0]    dir;

  omx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  omx_datapath #(
    .PWM_BITS       (PWM_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_brake         (in_chan.brake),
    .in_direction_deg (in_chan.direction_deg),
    .in_speed_cmd     (in_chan.speed_cmd),
    .in_turn_cmd      (in_chan.turn_cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pwm              (pwm),
    .dir              (dir)
  );

  assign out_chan.fl_pwm = pwm[0];
  assign out_chan.fr_pwm = pwm[1];
  assign out_chan.bl_pwm = pwm[2];
  assign out_chan.br_pwm = pwm[3];
  assign out_chan.fl_dir = dir[0];
  assign out_chan.fr_dir = dir[1];
  assign out_chan.bl_dir = dir[2];
  assign out_chan.br_dir = dir[3];

endmodule

`default_nettype wire

// ----- hdl/omx_ctrl.sv -----
// omx_ctrl: sequencer for the mixer, steps the shared multiplier and the wheel stage
// depends on omx_pkg for state, command and status types
`default_nettype none

module omx_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  omx_pkg::omx_stat_t  stat,
  output omx_pkg::omx_cmd_t   cmd
);

  omx_pkg::state_t                    state_r, state_nxt;
  logic [omx_pkg::WHEEL_W-1:0]        wheel_r, wheel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= omx_pkg::ST_IDLE;
      wheel_r <= '0;
    end else begin
      state_r <= state_nxt;
      wheel_r <= wheel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wheel_nxt = '0;
    unique case (state_r)
      omx_pkg::ST_IDLE:  if (in_valid) state_nxt = omx_pkg::ST_TRIG;
      omx_pkg::ST_TRIG:  state_nxt = stat.brake ? omx_pkg::ST_OUT : omx_pkg::ST_SUMP;
      omx_pkg::ST_SUMP:  state_nxt = omx_pkg::ST_SUMM;
      omx_pkg::ST_SUMM:  state_nxt = omx_pkg::ST_VELP;
      omx_pkg::ST_VELP:  state_nxt = omx_pkg::ST_VELM;
      omx_pkg::ST_VELM:  state_nxt = omx_pkg::ST_WHEEL;
      omx_pkg::ST_WHEEL: begin
        wheel_nxt = wheel_r + 1'b1;
        if (wheel_r == omx_pkg::WHEEL_W'(omx_pkg::WHEELS - 1)) begin
          state_nxt = omx_pkg::ST_OUT;
        end
      end
      omx_pkg::ST_OUT:   if (out_ready) state_nxt = omx_pkg::ST_IDLE;
      default:           state_nxt = omx_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.load      = 1'b0;
    cmd.trig      = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.mul_sel   = omx_pkg::MUL_SUMP;
    cmd.wheel_en  = 1'b0;
    cmd.wheel_idx = wheel_r;
    unique case (state_r)
      omx_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      omx_pkg::ST_TRIG:  cmd.trig = 1'b1;
      omx_pkg::ST_SUMP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = omx_pkg::MUL_SUMP;
      end
      omx_pkg::ST_SUMM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = omx_pkg::MUL_SUMM;
      end
      omx_pkg::ST_VELP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = omx_pkg::MUL_VELP;
      end
      omx_pkg::ST_VELM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = omx_pkg::MUL_VELM;
      end
      omx_pkg::ST_WHEEL: cmd.wheel_en = 1'b1;
      omx_pkg::ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/omx_datapath.sv -----
// omx_datapath: trig lookup, shared multiplier, per-wheel mix/round/clamp and the
// configuration registers; depends on omx_pkg
`default_nettype none

module omx_datapath #(
  parameter int PWM_BITS       = omx_pkg::PWM_BITS_DEF,
  parameter int TRIG_FRAC_BITS = omx_pkg::TRIG_FRAC_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  omx_pkg::omx_cmd_t                   cmd,
  output omx_pkg::omx_stat_t                  stat,
  input  wire                                 in_brake,
  input  wire signed [omx_pkg::DEG_W-1:0]     in_direction_deg,
  input  wire signed [omx_pkg::VEL_W-1:0]     in_speed_cmd,
  input  wire signed [omx_pkg::TURN_W-1:0]    in_turn_cmd,
  input  wire                                 cfg_we,
  input  wire [omx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [omx_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic [omx_pkg::PWM_W-1:0]           pwm [omx_pkg::WHEELS],
  output logic [omx_pkg::WHEELS-1:0]          dir
);

  localparam int F    = TRIG_FRAC_BITS;
  localparam int TW   = F + 2;
  localparam int MA   = 2 * F + 3;
  localparam int MB   = F + 2;
  localparam int MP   = MA + MB;
  localparam int WT   = 2 * F + 13;
  localparam int RW   = WT - 2 * F;
  localparam int CW   = ((PWM_BITS > RW) ? PWM_BITS : RW) + 1;
  localparam logic [omx_pkg::TRIG_MAG_W-1:0] C45_M = omx_pkg::trig_mag(7'd45, F);
  localparam logic signed [MB-1:0]  C45_S     = {1'b0, C45_M[F:0]};
  localparam logic [WT-1:0]         HALF      = WT'(1) << (2 * F - 1);
  localparam logic [CW-1:0]         PWM_LIMIT = (CW'(1) << PWM_BITS) - CW'(1);

  logic                               brake_r;
  logic signed [omx_pkg::DEG_W-1:0]   deg_r;
  logic signed [omx_pkg::VEL_W-1:0]   vel_r;
  logic signed [omx_pkg::TURN_W-1:0]  turn_r;
  logic signed [TW-1:0]               x_r, y_r;
  logic signed [MA-1:0]               sum_p_r, sum_m_r;
  logic signed [WT-1:0]               tot_p_r, tot_m_r;
  logic [omx_pkg::PWM_W-1:0]          pwm_r [omx_pkg::WHEELS];
  logic [omx_pkg::WHEELS-1:0]         dir_r;
  logic [omx_pkg::SPEED_W-1:0]        stall_r, max_r;
  logic [omx_pkg::WHEELS-1:0]         rev_r;

  function automatic logic signed [TW-1:0] sine_q(input logic [omx_pkg::DEG_W-1:0] a);
    logic [6:0]                        idx;
    logic                              neg;
    logic [omx_pkg::TRIG_MAG_W-1:0]    m;
    logic signed [TW-1:0]              v;
    if (a <= 9'd90) begin
      idx = a[6:0];
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      idx = 7'(9'd180 - a);
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      idx = 7'(a - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - a);
      neg = 1'b1;
    end
    m = omx_pkg::trig_mag(idx, F);
    v = {1'b0, m[F:0]};
    return neg ? -v : v;
  endfunction

  // angle reduction to [0, 360) and the cosine angle
  logic signed [omx_pkg::DEG_W:0]  deg_s;
  logic [omx_pkg::DEG_W:0]         deg_w, cdeg_w;
  logic [omx_pkg::DEG_W-1:0]       deg_u, cdeg_u;

  always_comb begin
    deg_s  = {deg_r[omx_pkg::DEG_W-1], deg_r};
    deg_w  = deg_s[omx_pkg::DEG_W] ? 10'(deg_s + 10'sd360) : 10'(deg_s);
    deg_u  = deg_w[omx_pkg::DEG_W-1:0];
    cdeg_w = {1'b0, deg_u} + 10'd90;
    cdeg_u = (cdeg_w >= 10'd360) ? 9'(cdeg_w - 10'd360) : cdeg_w[omx_pkg::DEG_W-1:0];
  end

  // shared multiplier
  logic signed [TW:0]    xy_p, xy_m;
  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic signed [MP-1:0]  prod;

  always_comb begin
    xy_p = {x_r[TW-1], x_r} + {y_r[TW-1], y_r};
    xy_m = {y_r[TW-1], y_r} - {x_r[TW-1], x_r};
    mul_a = {{(MA-TW-1){xy_p[TW]}}, xy_p};
    mul_b = C45_S;
    case (cmd.mul_sel)
      omx_pkg::MUL_SUMP: mul_a = {{(MA-TW-1){xy_p[TW]}}, xy_p};
      omx_pkg::MUL_SUMM: mul_a = {{(MA-TW-1){xy_m[TW]}}, xy_m};
      omx_pkg::MUL_VELP: begin
        mul_a = sum_p_r;
        mul_b = {{(MB-omx_pkg::VEL_W){vel_r[omx_pkg::VEL_W-1]}}, vel_r};
      end
      omx_pkg::MUL_VELM: begin
        mul_a = sum_m_r;
        mul_b = {{(MB-omx_pkg::VEL_W){vel_r[omx_pkg::VEL_W-1]}}, vel_r};
      end
      default: ;
    endcase
    prod = MP'(mul_a) * MP'(mul_b);
  end

  // one wheel: mix, round half away from zero, stall and clamp
  logic                        use_minus, add_turn, neg, pos, stalled;
  logic signed [WT-1:0]        base, turn_s, total;
  logic [WT-1:0]               mag, rnd;
  logic [RW-1:0]               r;
  logic [CW-1:0]               rc;
  logic [omx_pkg::PWM_W-1:0]   pwm_w;
  logic                        dir_w;

  always_comb begin
    use_minus = (cmd.wheel_idx == 2'd1) || (cmd.wheel_idx == 2'd2);
    add_turn  = (cmd.wheel_idx == 2'd0) || (cmd.wheel_idx == 2'd2);
    base      = use_minus ? tot_m_r : tot_p_r;
    turn_s    = {{(WT-omx_pkg::TURN_W){turn_r[omx_pkg::TURN_W-1]}}, turn_r} << (2 * F - 2);
    total     = add_turn ? base + turn_s : base - turn_s;
    neg       = total[WT-1];
    mag       = neg ? WT'(-total) : WT'(total);
    rnd       = mag + HALF;
    r         = rnd[WT-1:2*F];
    pos       = !neg && (r != '0);
    stalled   = r < RW'(stall_r);
    rc        = (r > RW'(max_r)) ? CW'(max_r) : CW'(r);
    if (rc > PWM_LIMIT) begin
      rc = PWM_LIMIT;
    end
    pwm_w     = stalled ? '0 : rc[omx_pkg::PWM_W-1:0];
    dir_w     = pos ? rev_r[cmd.wheel_idx] : ~rev_r[cmd.wheel_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      brake_r <= in_brake;
      deg_r   <= in_direction_deg;
      vel_r   <= in_speed_cmd;
      turn_r  <= in_turn_cmd;
    end
    if (cmd.trig) begin
      x_r <= sine_q(deg_u);
      y_r <= sine_q(cdeg_u);
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        omx_pkg::MUL_SUMP: sum_p_r <= prod[MA-1:0];
        omx_pkg::MUL_SUMM: sum_m_r <= prod[MA-1:0];
        omx_pkg::MUL_VELP: tot_p_r <= prod[WT-1:0];
        omx_pkg::MUL_VELM: tot_m_r <= prod[WT-1:0];
        default: ;
      endcase
    end
    if (cmd.load && in_brake) begin
      for (int k = 0; k < omx_pkg::WHEELS; k++) begin
        pwm_r[k] <= '0;
      end
    end else if (cmd.wheel_en) begin
      pwm_r[cmd.wheel_idx] <= pwm_w;
    end
  end

  // dir_r doubles as the held directions across brake requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= '0;
      stall_r <= '0;
      max_r   <= '1;
      rev_r   <= '0;
    end else begin
      if (cmd.wheel_en) begin
        dir_r[cmd.wheel_idx] <= dir_w;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          omx_pkg::REG_STALL:   stall_r <= cfg_wdata[omx_pkg::SPEED_W-1:0];
          omx_pkg::REG_MAX:     max_r   <= cfg_wdata[omx_pkg::SPEED_W-1:0];
          omx_pkg::REG_REVERSE: rev_r   <= cfg_wdata[omx_pkg::WHEELS-1:0];
          default: ;
        endcase
      end
    end
  end

  assign stat.brake = brake_r;
  assign pwm        = pwm_r;
  assign dir        = dir_r;

endmodule

`default_nettype wire

// ----- hdl/omx_checker.sv -----
// omx_checker: port-level assertions for the omni wheel motor mixer and its bind
// depends on omx_pkg and omni_wheel_motor_mixer
`default_nettype none

module omx_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            in_brake,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [omx_pkg::PWM_W-1:0]       fl_pwm,
  input wire [omx_pkg::PWM_W-1:0]       fr_pwm,
  input wire [omx_pkg::PWM_W-1:0]       bl_pwm,
  input wire [omx_pkg::PWM_W-1:0]       br_pwm,
  input wire                            fl_dir,
  input wire                            fr_dir,
  input wire                            bl_dir,
  input wire                            br_dir
);

  logic [omx_pkg::WHEELS-1:0] dirs;
  assign dirs = {br_dir, bl_dir, fr_dir, fl_dir};

  // one request in flight: never open for a request while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fl_pwm) && $stable(fr_pwm)
      && $stable(bl_pwm) && $stable(br_pwm) && $stable(dirs))
    else $error("stalled result changed");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown in the cycle after a request");

  // brake gives zero pwm and repeats the directions held when the request was taken
  a_brake: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_brake |=> ##1 out_valid && fl_pwm == '0 && fr_pwm == '0
      && bl_pwm == '0 && br_pwm == '0 && dirs == $past(dirs, 2))
    else $error("brake result wrong");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind omni_wheel_motor_mixer omx_checker u_omx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_brake  (in_chan.brake),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .fl_pwm    (out_chan.fl_pwm),
  .fr_pwm    (out_chan.fr_pwm),
  .bl_pwm    (out_chan.bl_pwm),
  .br_pwm    (out_chan.br_pwm),
  .fl_dir    (out_chan.fl_dir),
  .fr_dir    (out_chan.fr_dir),
  .bl_dir    (out_chan.bl_dir),
  .br_dir    (out_chan.br_dir)
);

`default_nettype wire
